// ===== src/image_resample_area_bilinear_top_defines.svh =====
// Assertion macros for the image resampler.
`ifndef IMAGE_RESAMPLE_AREA_BILINEAR_TOP_DEFINES_SVH
`define IMAGE_RESAMPLE_AREA_BILINEAR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IMGRS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define IMGRS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error("assertion failed");
`else
`define IMGRS_ASSERT(label, prop)
`define IMGRS_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== src/imgrs_pkg.sv =====
// Shared types, constants and codes of the image resampler.
package imgrs_pkg;

  localparam int SRC_PIXELS = 4096;
  localparam int MAX_DIM    = 2048;
  localparam int ADDR_W     = 12;
  localparam int DIM_W      = 12;
  localparam int POS_W      = 11;
  localparam int SPAN_W     = 23;
  localparam int WT_W       = 13;
  localparam int W_W        = 26;
  localparam int SUM_W      = 34;
  localparam int DIVR_W     = 34;
  localparam int NUM_W      = 42;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE     = 3'd4;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [11:0] pixel_index;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [10:0] target_x;
    logic [10:0] target_y;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       status;
  } out_t;

  typedef struct packed {
    logic [DIM_W-1:0] source_width;
    logic [DIM_W-1:0] source_height;
    logic [DIM_W-1:0] target_width;
    logic [DIM_W-1:0] target_height;
    logic [7:0]       max_value;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] index;
    logic [23:0]       rgb;
    logic [POS_W-1:0]  tx;
    logic [POS_W-1:0]  ty;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic [WT_W-1:0]   denom;
    logic              blend;
    logic [SPAN_W-1:0] span_start;
    logic [SPAN_W-1:0] span_end;
    logic [DIM_W-1:0]  step;
    logic [SPAN_W-1:0] astart;
  } plan_t;

endpackage

// ===== src/image_resample_area_bilinear_top.sv =====
// Top level of the image resampler: configuration registers, front and back ends.
//
// Input channel (in_valid/in_ready/in_data) carries two kinds of transaction:
// a pixel write (req_type 0) stores one RGB pixel at pixel_index, and a
// sample request (req_type 1) asks for the resized pixel at target_x,target_y.
// Each sample request gives exactly one transaction on the output channel
// (out_valid/out_ready/out_data); writes give none. status 1 flags a bad
// coordinate, size or max value setting, with all channels zero.
// Configuration: cfg_write with cfg_index 0..4 sets source width, source
// height, target width, target height and max value; write only while idle.
// A write is stored by the back end while it is idle; an error sample goes
// straight to the result. A sample plans each axis (none, one or two
// divisions on the radix-2 divider), walks the window row by row through
// the single pixel store read port, scales the channels and loads the result.
// One sample is worked on at a time.
// A two-entry queue sits between front and back; out_data is registered, so
// the back end finishes the next item while a result waits. A stalled
// receiver holds the result and fills the queue, then in_ready drops.
// Reset (rst, synchronous) empties the queue and restores the default sizes
// 1x1 and max value 255; the pixel store is not cleared.
module image_resample_area_bilinear_top import imgrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= DIM_W'(1);
      cfg.source_height <= DIM_W'(1);
      cfg.target_width  <= DIM_W'(1);
      cfg.target_height <= DIM_W'(1);
      cfg.max_value     <= 8'd255;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SOURCE_WIDTH:  cfg.source_width  <= cfg_data;
        CFG_SOURCE_HEIGHT: cfg.source_height <= cfg_data;
        CFG_TARGET_WIDTH:  cfg.target_width  <= cfg_data;
        CFG_TARGET_HEIGHT: cfg.target_height <= cfg_data;
        CFG_MAX_VALUE:     cfg.max_value     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  imgrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  imgrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/imgrs_div.sv =====
// Radix-2 restoring divider for the axis plans, one quotient bit a cycle.
module imgrs_div import imgrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SPAN_W-1:0] num,
  input  logic [WT_W-1:0]   den,
  output logic              busy,
  output logic              done,
  output logic [SPAN_W-1:0] quot,
  output logic [WT_W-1:0]   rem
);

  logic [WT_W:0]     r;
  logic [WT_W:0]     r_sh;
  logic [WT_W:0]     r_next;
  logic [SPAN_W-1:0] q;
  logic [SPAN_W-1:0] q_next;
  logic [WT_W-1:0]   d;
  logic [4:0]        cnt;

  always_comb begin
    r_sh = {r[WT_W-1:0], q[SPAN_W-1]};
    if (r_sh >= {1'b0, d}) begin
      r_next = r_sh - {1'b0, d};
      q_next = {q[SPAN_W-2:0], 1'b1};
    end else begin
      r_next = r_sh;
      q_next = {q[SPAN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        r    <= '0;
        q    <= num;
        d    <= den;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        r   <= r_next;
        q   <= q_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'(SPAN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
  assign rem  = r[WT_W-1:0];

endmodule

// ===== src/imgrs_front.sv =====
// Front end: accepts transactions, classifies them and queues them for the back end.
module imgrs_front import imgrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic [23:0] area;
  logic       bad;
  logic       push;
  logic       pop;

  function automatic logic dim_ok(logic [DIM_W-1:0] dv);
    return dv != '0 && dv <= DIM_W'(MAX_DIM);
  endfunction

  always_comb begin
    area = {12'd0, cfg.source_width} * {12'd0, cfg.source_height};
    bad  = !dim_ok(cfg.source_width) || !dim_ok(cfg.source_height) ||
           !dim_ok(cfg.target_width) || !dim_ok(cfg.target_height) ||
           cfg.max_value == 8'd0 || area > 24'(SRC_PIXELS) ||
           {1'b0, in_data.target_x} >= cfg.target_width ||
           {1'b0, in_data.target_y} >= cfg.target_height;
    cmd_in.index = in_data.pixel_index;
    cmd_in.rgb   = {in_data.in_red, in_data.in_green, in_data.in_blue};
    cmd_in.tx    = in_data.target_x;
    cmd_in.ty    = in_data.target_y;
    if (!in_data.req_type) begin
      cmd_in.kind = KIND_WRITE;
    end else if (bad) begin
      cmd_in.kind = KIND_ERROR;
    end else begin
      cmd_in.kind = KIND_SAMPLE;
    end
  end

  assign in_ready = count != 2'd2;
  assign q_valid  = count != 2'd0;
  assign q_cmd    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/imgrs_back.sv =====
// Back end: pixel store, axis planning, window walk and channel scaling.
`include "image_resample_area_bilinear_top_defines.svh"
module imgrs_back import imgrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PM1   = 4'd1;
  localparam logic [3:0] S_PM2   = 4'd2;
  localparam logic [3:0] S_PD1   = 4'd3;
  localparam logic [3:0] S_PW1   = 4'd4;
  localparam logic [3:0] S_PW2   = 4'd5;
  localparam logic [3:0] S_PDEN  = 4'd6;
  localparam logic [3:0] S_WINIT = 4'd7;
  localparam logic [3:0] S_WY    = 4'd8;
  localparam logic [3:0] S_ADDR  = 4'd9;
  localparam logic [3:0] S_MAC   = 4'd10;
  localparam logic [3:0] S_DVI   = 4'd11;
  localparam logic [3:0] S_DVS   = 4'd12;
  localparam logic [3:0] S_DVK   = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;

  logic [23:0]       pix_mem [SRC_PIXELS];
  logic [23:0]       mem_rdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic [3:0]        state;
  logic              axis;
  logic              err;
  logic [POS_W-1:0]  tx;
  logic [POS_W-1:0]  ty;
  logic [SPAN_W-1:0] ss;
  logic [24:0]       cval;
  logic [24:0]       lim;
  plan_t             plans [2];
  logic [W_W-1:0]    den;
  logic [ADDR_W-1:0] rowbase;
  logic [POS_W-1:0]  sx;
  logic [POS_W-1:0]  sy;
  logic [SPAN_W-1:0] ax;
  logic [SPAN_W-1:0] ay;
  logic [WT_W-1:0]   wy;
  logic [W_W-1:0]    w;
  logic [SUM_W-1:0]  sums [3];
  logic [DIVR_W-1:0] divr;
  logic [1:0]        ch;
  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dsh;
  logic [7:0]        qv;
  logic [2:0]        bitc;
  logic [7:0]        res [3];

  logic [DIM_W-1:0]  src_a;
  logic [DIM_W-1:0]  tgt_a;
  logic [POS_W-1:0]  pos_a;
  logic              down;
  logic [24:0]       c_calc;
  logic [SPAN_W-1:0] se_calc;
  logic              div_start;
  logic [SPAN_W-1:0] div_num;
  logic [WT_W-1:0]   div_den;
  logic              div_busy;
  logic              div_done;
  logic [SPAN_W-1:0] div_quot;
  logic [WT_W-1:0]   div_rem;
  plan_t             plan_h;
  plan_t             plan_v;
  logic [WT_W-1:0]   wx;
  logic [NUM_W-1:0]  num_calc;
  logic [7:0]        qv_next;
  logic [NUM_W-1:0]  rem_next;
  logic              emit_go;
  logic              out_zero;

  function automatic logic [WT_W-1:0] axis_weight(plan_t p, logic [POS_W-1:0] s,
                                                  logic [SPAN_W-1:0] a);
    logic [SPAN_W-1:0] b;
    logic [SPAN_W-1:0] os;
    logic [SPAN_W-1:0] oe;
    b  = a + SPAN_W'(p.step);
    os = p.span_start > a ? p.span_start : a;
    oe = p.span_end < b ? p.span_end : b;
    if (p.lo == p.hi) begin
      return p.denom;
    end else if (p.blend) begin
      return s == p.lo ? p.denom - p.span_start[WT_W-1:0] : p.span_start[WT_W-1:0];
    end else begin
      return oe > os ? WT_W'(oe - os) : '0;
    end
  endfunction

  assign plan_h  = plans[0];
  assign plan_v  = plans[1];
  assign src_a   = axis ? cfg.source_height : cfg.source_width;
  assign tgt_a   = axis ? cfg.target_height : cfg.target_width;
  assign pos_a   = axis ? ty : tx;
  assign down    = tgt_a < src_a;
  assign c_calc  = {1'b0, ss, 1'b0} + {13'd0, src_a} - {13'd0, tgt_a};
  assign se_calc = ss + SPAN_W'(src_a);
  assign wx      = axis_weight(plan_h, sx, ax);
  assign mem_raddr = rowbase + ADDR_W'(sx);
  assign q_ready = state == S_IDLE;
  assign emit_go = !out_valid || out_ready;
  assign num_calc = {sums[ch], 8'd0} - NUM_W'(sums[ch]) + NUM_W'(divr >> 1);
  assign out_zero = out_data.out_red == 8'd0 && out_data.out_green == 8'd0 &&
                    out_data.out_blue == 8'd0;

  always_comb begin
    if (rem_r >= dsh) begin
      rem_next = rem_r - dsh;
      qv_next  = qv | (8'd1 << bitc);
    end else begin
      rem_next = rem_r;
      qv_next  = qv;
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = ss;
    div_den   = WT_W'(tgt_a);
    unique case (state)
      S_PD1: begin
        if (down) begin
          div_start = 1'b1;
        end else if (!cval[24] && cval != '0 && cval < lim) begin
          div_start = 1'b1;
          div_num   = cval[SPAN_W-1:0];
          div_den   = {tgt_a, 1'b0};
        end
      end
      S_PW1: begin
        if (div_done && plans[axis].blend == 1'b0) begin
          div_start = 1'b1;
          div_num   = se_calc - SPAN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  imgrs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && q_cmd.kind == KIND_WRITE &&
        {1'b0, q_cmd.index} < 13'(SRC_PIXELS)) begin
      pix_mem[q_cmd.index] <= q_cmd.rgb;
    end
    mem_rdata <= pix_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            tx   <= q_cmd.tx;
            ty   <= q_cmd.ty;
            axis <= 1'b0;
            if (q_cmd.kind == KIND_SAMPLE) begin
              err   <= 1'b0;
              state <= S_PM1;
            end else if (q_cmd.kind == KIND_ERROR) begin
              err    <= 1'b1;
              res[0] <= '0;
              res[1] <= '0;
              res[2] <= '0;
              state  <= S_EMIT;
            end
          end
        end
        S_PM1: begin
          ss    <= {12'd0, pos_a} * {11'd0, src_a};
          state <= S_PM2;
        end
        S_PM2: begin
          lim   <= {13'd0, src_a - DIM_W'(1)} * {12'd0, tgt_a, 1'b0};
          cval  <= c_calc;
          plans[axis].denom      <= down ? WT_W'(src_a) : {tgt_a, 1'b0};
          plans[axis].step       <= tgt_a;
          plans[axis].blend      <= !down;
          plans[axis].span_start <= ss;
          plans[axis].span_end   <= se_calc;
          plans[axis].astart     <= '0;
          state <= S_PD1;
        end
        S_PD1: begin
          if (down || div_start) begin
            state <= S_PW1;
          end else begin
            if (cval[24] || cval == '0) begin
              plans[axis].lo <= '0;
              plans[axis].hi <= '0;
            end else begin
              plans[axis].lo <= POS_W'(src_a - DIM_W'(1));
              plans[axis].hi <= POS_W'(src_a - DIM_W'(1));
            end
            plans[axis].span_start <= '0;
            axis  <= 1'b1;
            state <= axis ? S_PDEN : S_PM1;
          end
        end
        S_PW1: begin
          if (div_done) begin
            plans[axis].lo <= div_quot[POS_W-1:0];
            if (plans[axis].blend) begin
              plans[axis].hi         <= div_quot[POS_W-1:0] + POS_W'(1);
              plans[axis].span_start <= SPAN_W'(div_rem);
              axis  <= 1'b1;
              state <= axis ? S_PDEN : S_PM1;
            end else begin
              plans[axis].astart <= ss - SPAN_W'(div_rem);
              state <= S_PW2;
            end
          end
        end
        S_PW2: begin
          if (div_done) begin
            if (div_quot >= SPAN_W'(src_a)) begin
              plans[axis].hi <= POS_W'(src_a - DIM_W'(1));
            end else begin
              plans[axis].hi <= div_quot[POS_W-1:0];
            end
            axis  <= 1'b1;
            state <= axis ? S_PDEN : S_PM1;
          end
        end
        S_PDEN: begin
          den   <= {13'd0, plan_h.denom} * {13'd0, plan_v.denom};
          state <= S_WINIT;
        end
        S_WINIT: begin
          rowbase <= ADDR_W'({12'd0, plan_v.lo} * {11'd0, cfg.source_width});
          sy      <= plan_v.lo;
          ay      <= plan_v.astart;
          sums[0] <= '0;
          sums[1] <= '0;
          sums[2] <= '0;
          state   <= S_WY;
        end
        S_WY: begin
          wy    <= axis_weight(plan_v, sy, ay);
          sx    <= plan_h.lo;
          ax    <= plan_h.astart;
          state <= S_ADDR;
        end
        S_ADDR: begin
          w     <= {13'd0, wy} * {13'd0, wx};
          state <= S_MAC;
        end
        S_MAC: begin
          sums[0] <= sums[0] + SUM_W'(mem_rdata[23:16]) * SUM_W'(w);
          sums[1] <= sums[1] + SUM_W'(mem_rdata[15:8]) * SUM_W'(w);
          sums[2] <= sums[2] + SUM_W'(mem_rdata[7:0]) * SUM_W'(w);
          if (sx < plan_h.hi) begin
            sx    <= sx + POS_W'(1);
            ax    <= ax + SPAN_W'(plan_h.step);
            state <= S_ADDR;
          end else if (sy < plan_v.hi) begin
            sy      <= sy + POS_W'(1);
            ay      <= ay + SPAN_W'(plan_v.step);
            rowbase <= rowbase + cfg.source_width;
            state   <= S_WY;
          end else begin
            state <= S_DVI;
          end
        end
        S_DVI: begin
          divr  <= DIVR_W'(den) * DIVR_W'(cfg.max_value);
          ch    <= '0;
          state <= S_DVS;
        end
        S_DVS: begin
          if (num_calc >= (NUM_W'(divr) << 8)) begin
            res[ch] <= 8'd255;
            ch      <= ch + 2'd1;
            state   <= ch == 2'd2 ? S_EMIT : S_DVS;
          end else begin
            rem_r <= num_calc;
            dsh   <= NUM_W'(divr) << 7;
            bitc  <= 3'd7;
            qv    <= '0;
            state <= S_DVK;
          end
        end
        S_DVK: begin
          rem_r <= rem_next;
          qv    <= qv_next;
          dsh   <= dsh >> 1;
          bitc  <= bitc - 3'd1;
          if (bitc == 3'd0) begin
            res[ch] <= qv_next;
            ch      <= ch + 2'd1;
            state   <= ch == 2'd2 ? S_EMIT : S_DVS;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_data.out_red   <= res[0];
            out_data.out_green <= res[1];
            out_data.out_blue  <= res[2];
            out_data.status    <= err;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `IMGRS_ASSERT(a_div_start_free, div_start |-> !div_busy)
  `IMGRS_ASSERT(a_err_zero, (out_valid && out_data.status) |-> out_zero)
  `IMGRS_ASSERT(a_walk_in_window, (state == S_ADDR) |-> (sx <= plan_h.hi && sy <= plan_v.hi))
  `IMGRS_ASSERT_NEXT(a_emit_loads, (state == S_EMIT && emit_go), (out_valid && state == S_IDLE))

endmodule

// ===== sim/image_resample_area_bilinear_top_test.sv =====
// Self-checking testbench for the image resampler: store writes, resized samples and bad settings.
module image_resample_area_bilinear_top_test;
  import imgrs_pkg::*;

  localparam int FILL_PIXELS = 512;

  typedef struct {
    int unsigned     lo;
    int unsigned     hi;
    longint unsigned den;
    longint unsigned span_lo;
    longint unsigned span_hi;
    longint unsigned pitch;
    bit              blend;
  } axis_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [23:0] pixel_store [SRC_PIXELS];
  int unsigned src_w, src_h, tgt_w, tgt_h, max_val;
  out_t        pending_pixels [$];
  int          errors;
  int          burst_left;
  int          stall_left;
  bit          stall_mode;

  image_resample_area_bilinear_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #64_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic axis_t plan_axis(input int unsigned src, input int unsigned tgt,
                                      input int unsigned pos);
    axis_t  a;
    longint d;
    longint c;
    a = '{default: 0};
    if (tgt < src) begin
      a.span_lo = longint'(pos) * src;
      a.span_hi = longint'(pos + 1) * src;
      a.pitch   = tgt;
      a.lo      = 32'(a.span_lo / a.pitch);
      a.hi      = 32'((a.span_hi - 1) / a.pitch);
      if (a.hi >= src) a.hi = src - 1;
      a.den = src;
    end else begin
      d       = longint'(tgt) * 2;
      c       = (longint'(pos) * 2 + 1) * longint'(src) - longint'(tgt);
      a.blend = 1'b1;
      a.den   = d;
      if (c <= 0) begin
        a.lo = 0;
        a.hi = 0;
      end else if (c >= longint'(src - 1) * d) begin
        a.lo = src - 1;
        a.hi = src - 1;
      end else begin
        a.lo      = 32'(c / d);
        a.hi      = a.lo + 1;
        a.span_lo = c - longint'(a.lo) * d;
      end
    end
    return a;
  endfunction

  function automatic longint unsigned axis_weight(input axis_t a, input int unsigned s);
    longint unsigned lo_edge, hi_edge, os, oe;
    if (a.lo == a.hi) return a.den;
    if (a.blend) return (s == a.lo) ? a.den - a.span_lo : a.span_lo;
    lo_edge = longint'(s) * a.pitch;
    hi_edge = lo_edge + a.pitch;
    os = (a.span_lo > lo_edge) ? a.span_lo : lo_edge;
    oe = (a.span_hi < hi_edge) ? a.span_hi : hi_edge;
    return (oe > os) ? oe - os : 0;
  endfunction

  function automatic logic [7:0] scale_level(input longint unsigned sum,
                                             input longint unsigned wt);
    longint unsigned div, v;
    div = wt * max_val;
    if (div == 0) return 8'd0;
    v = (sum * 255 + div / 2) / div;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic bit dim_bad(input int unsigned d);
    return d < 1 || d > MAX_DIM;
  endfunction

  function automatic out_t resample_pixel(input int unsigned tx, input int unsigned ty);
    out_t            r;
    axis_t           h, v;
    longint unsigned sum_r, sum_g, sum_b, wy, w;
    logic [23:0]     px;
    r = '{out_red: 8'd0, out_green: 8'd0, out_blue: 8'd0, status: 1'b1};
    if (dim_bad(src_w) || dim_bad(src_h) || dim_bad(tgt_w) || dim_bad(tgt_h) ||
        max_val == 0 || src_w * src_h > SRC_PIXELS || tx >= tgt_w || ty >= tgt_h)
      return r;
    h = plan_axis(src_w, tgt_w, tx);
    v = plan_axis(src_h, tgt_h, ty);
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int unsigned sy = v.lo; sy <= v.hi; sy++) begin
      wy = axis_weight(v, sy);
      for (int unsigned sx = h.lo; sx <= h.hi; sx++) begin
        w  = wy * axis_weight(h, sx);
        px = pixel_store[sy * src_w + sx];
        sum_r += px[23:16] * w;
        sum_g += px[15:8] * w;
        sum_b += px[7:0] * w;
      end
    end
    r.out_red   = scale_level(sum_r, h.den * v.den);
    r.out_green = scale_level(sum_g, h.den * v.den);
    r.out_blue  = scale_level(sum_b, h.den * v.den);
    r.status    = 1'b0;
    return r;
  endfunction

  task automatic send_item(input in_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (item.req_type) begin
      pending_pixels.push_back(resample_pixel(item.target_x, item.target_y));
    end else begin
      pixel_store[item.pixel_index] = {item.in_red, item.in_green, item.in_blue};
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_SOURCE_WIDTH:  src_w = val & 12'hFFF;
      CFG_SOURCE_HEIGHT: src_h = val & 12'hFFF;
      CFG_TARGET_WIDTH:  tgt_w = val & 12'hFFF;
      CFG_TARGET_HEIGHT: tgt_h = val & 12'hFFF;
      CFG_MAX_VALUE:     max_val = val & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic set_sizes(input int unsigned sw, input int unsigned sh, input int unsigned tw,
                           input int unsigned th, input int unsigned mv);
    drain();
    write_reg(CFG_SOURCE_WIDTH, sw);
    write_reg(CFG_SOURCE_HEIGHT, sh);
    write_reg(CFG_TARGET_WIDTH, tw);
    write_reg(CFG_TARGET_HEIGHT, th);
    write_reg(CFG_MAX_VALUE, mv);
  endtask

  function automatic in_t pixel_write(input int unsigned idx);
    in_t         t;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    t = raw[$bits(in_t)-1:0];
    t.req_type    = 1'b0;
    t.pixel_index = ADDR_W'(idx);
    return t;
  endfunction

  function automatic in_t sample_at(input int unsigned x, input int unsigned y);
    in_t         t;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    t = raw[$bits(in_t)-1:0];
    t.req_type = 1'b1;
    t.target_x = POS_W'(x);
    t.target_y = POS_W'(y);
    return t;
  endfunction

  function automatic in_t random_item;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return pixel_write($urandom_range(0, SRC_PIXELS - 1));
    if (pick < 28) return sample_at($urandom_range(0, 2047), $urandom_range(0, 2047));
    return sample_at($urandom_range(0, (tgt_w > 2048 ? 2048 : tgt_w) - 1),
                     $urandom_range(0, (tgt_h > 2048 ? 2048 : tgt_h) - 1));
  endfunction

  task automatic test_store_fill;
    for (int i = 0; i < FILL_PIXELS; i++) send_item(pixel_write(i));
  endtask

  task automatic test_directed;
    in_t t;
    set_sizes(2, 2, 1, 1, 255);
    t = pixel_write(0);
    {t.in_red, t.in_green, t.in_blue} = 24'hFF00FF;
    send_item(t);
    t = pixel_write(SRC_PIXELS - 1);
    {t.in_red, t.in_green, t.in_blue} = 24'h00FF00;
    send_item(t);
    send_item(sample_at(0, 0));
    send_item(sample_at(1, 0));
    send_item(sample_at(0, 2047));
    set_sizes(2, 2, 5, 3, 255);
    send_item(sample_at(0, 0));
    send_item(sample_at(4, 2));
    send_item(sample_at(2, 1));
    set_sizes(512, 1, 1, 1, 255);
    send_item(sample_at(0, 0));
    set_sizes(256, 2, 3, 2, 255);
    send_item(sample_at(2, 1));
    set_sizes(1, 1, 2048, 2048, 1);
    send_item(sample_at(2047, 2047));
    send_item(sample_at(0, 0));
    set_sizes(2, 256, 2, 2048, 200);
    send_item(sample_at(1, 2047));
  endtask

  task automatic test_bad_settings;
    set_sizes(0, 4, 4, 4, 255);
    send_item(sample_at(0, 0));
    set_sizes(4, 4, 4095, 2049, 255);
    send_item(sample_at(1, 1));
    set_sizes(100, 100, 4, 4, 255);
    send_item(sample_at(1, 1));
    set_sizes(4, 4, 4, 0, 255);
    send_item(sample_at(1, 0));
    set_sizes(4, 4, 4, 4, 0);
    send_item(sample_at(1, 1));
    send_item(pixel_write(7));
  endtask

  task automatic test_random;
    int unsigned pick;
    int unsigned sw;
    int unsigned sh;
    for (int ph = 0; ph < 8; ph++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        do begin
          sw = $urandom_range(0, 4095);
          sh = $urandom_range(0, 4095);
        end while (!dim_bad(sw) && !dim_bad(sh) && sw * sh <= SRC_PIXELS &&
                   sw * sh > FILL_PIXELS);
        set_sizes(sw, sh, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 255));
      end else begin
        set_sizes($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 32),
                  $urandom_range(1, 32), (pick < 6) ? 255 : $urandom_range(1, 255));
      end
      repeat (80) send_item(random_item());
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 40);
      stall_mode = ($urandom_range(0, 2) == 0);
    end
    stall_left--;
    out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report("result with none expected");
      end else begin
        automatic out_t e = pending_pixels.pop_front();
        if (out_data.out_red !== e.out_red)
          report($sformatf("red %0d, want %0d", out_data.out_red, e.out_red));
        if (out_data.out_green !== e.out_green)
          report($sformatf("green %0d, want %0d", out_data.out_green, e.out_green));
        if (out_data.out_blue !== e.out_blue)
          report($sformatf("blue %0d, want %0d", out_data.out_blue, e.out_blue));
        if (out_data.status !== e.status)
          report($sformatf("status %0d, want %0d", out_data.status, e.status));
      end
    end
  end

  initial begin
    errors     = 0;
    burst_left = 0;
    stall_left = 0;
    stall_mode = 1'b0;
    src_w      = 1;
    src_h      = 1;
    tgt_w      = 1;
    tgt_h      = 1;
    max_val    = 255;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_store_fill();
    test_directed();
    test_bad_settings();
    test_random();
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
